@@ design/btmx_pkg.sv @@
package btmx_pkg;

  // Width of the key and result ports.
  localparam int unsigned KEY_W = 31;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

@@ design/binary_trie_max_xor.sv @@
// Binary trie for maximum-XOR queries over KEY_BITS-bit keys.
//
// The input channel (in_valid/in_ready) carries one operation per transfer:
// clear the trie, insert a key, or query the largest XOR of a key with any
// stored key. Each operation yields exactly one result transfer on the output
// channel (out_valid/out_ready) with best_xor, trie_empty and pool_full.
//
// Insert and query walk the trie one level per cycle: every cycle reads one
// node from the single node pool memory, whose registered read data feeds the
// next level's decision. An insert or query goes from the idle state through
// the walk state to the done state; clear, an unused selector, a rejected insert
// and a query on an empty trie go from idle straight to done. One operation is
// in flight at a time: no new input is taken until the last one leaves done.
//
// Reset (and a clear) sets the free node pointer back to one and leaves the pool
// untouched. Nodes at or above the free pointer are treated as empty, and a node is
// written whole when a child is first linked from it, so no clearing pass is needed.
//
// The result sits in an output register. When the receiver stalls, the block takes and
// runs the next input, then holds its result in the final state until the register frees.
module binary_trie_max_xor
  import btmx_pkg::*;
#(
  parameter int unsigned KEY_BITS = 31,
  parameter int unsigned NODES    = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_func,
  input  logic [KEY_W-1:0] in_key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KEY_W-1:0] out_best_xor,
  output logic             out_trie_empty,
  output logic             out_pool_full
);

  localparam int unsigned LINK_W = $clog2(NODES);
  localparam int unsigned FREE_W = $clog2(NODES + 1);
  localparam int unsigned LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int unsigned ENT_W  = 2 * LINK_W;

  // Node pool: each entry holds the child link for bit one (upper half) and
  // the child link for bit zero (lower half). A zero link means no child.
  logic [ENT_W-1:0] pool_mem [NODES];

  state_t            state_r, state_nxt;
  func_t             func_r, func_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [LINK_W-1:0] node_r, node_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [KEY_W-1:0]  acc_r, acc_nxt;
  logic              fresh_r, fresh_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic              empty_r, empty_nxt;
  logic              full_r, full_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]  out_best_r, out_best_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic              out_full_r, out_full_nxt;

  logic [ENT_W-1:0]  rd_data_r;
  logic [LINK_W-1:0] rd_addr;
  logic              wr_en;
  logic [ENT_W-1:0]  wr_data;

  logic [LINK_W-1:0] link0, link1, same_link, opp_link, free_link;
  logic [KEY_W-1:0]  key_sh;
  logic              kbit;
  logic [FREE_W:0]   room_need;
  logic              no_room;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Current key bit; levels above the key port width see a zero bit.
  assign key_sh = key_r >> lvl_r;
  assign kbit   = key_sh[0];

  // A freshly allocated node has never been written since the last clear.
  assign link0     = fresh_r ? '0 : rd_data_r[LINK_W-1:0];
  assign link1     = fresh_r ? '0 : rd_data_r[ENT_W-1:LINK_W];
  assign same_link = kbit ? link1 : link0;
  assign opp_link  = kbit ? link0 : link1;
  assign free_link = free_r[LINK_W-1:0];

  // An insert needs KEY_BITS free nodes in the worst case.
  assign room_need = {1'b0, free_r} + (FREE_W + 1)'(KEY_BITS);
  assign no_room   = room_need > (FREE_W + 1)'(NODES);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    node_nxt      = node_r;
    lvl_nxt       = lvl_r;
    acc_nxt       = acc_r;
    fresh_nxt     = fresh_r;
    free_nxt      = free_r;
    empty_nxt     = empty_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_best_nxt  = out_best_r;
    out_empty_nxt = out_empty_r;
    out_full_nxt  = out_full_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_data       = kbit ? {free_link, link0} : {link1, free_link};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt  = func_t'(in_func);
          key_nxt   = in_key;
          node_nxt  = '0;
          lvl_nxt   = LVL_W'(KEY_BITS - 1);
          acc_nxt   = '0;
          fresh_nxt = (free_r == FREE_W'(1));
          empty_nxt = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = ST_DONE;
          unique case (func_t'(in_func))
            FUNC_CLEAR: begin
              free_nxt = FREE_W'(1);
            end
            FUNC_INSERT: begin
              if (no_room) begin
                full_nxt = 1'b1;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            FUNC_QUERY: begin
              if (free_r == FREE_W'(1)) begin
                empty_nxt = 1'b1;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_WALK: begin
        if (func_r == FUNC_INSERT) begin
          if (same_link == '0) begin
            // Link a new node from the free pointer; everything below it
            // is new as well.
            wr_en     = 1'b1;
            node_nxt  = free_link;
            free_nxt  = free_r + FREE_W'(1);
            fresh_nxt = 1'b1;
          end else begin
            node_nxt = same_link;
          end
        end else begin
          if (opp_link != '0) begin
            acc_nxt  = acc_r | (KEY_W'(1) << lvl_r);
            node_nxt = opp_link;
          end else begin
            node_nxt = same_link;
          end
        end
        rd_addr = node_nxt;
        if (lvl_r == '0) begin
          state_nxt = ST_DONE;
        end else if (func_r == FUNC_QUERY && opp_link == '0 && same_link == '0) begin
          state_nxt = ST_DONE;
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_best_nxt  = acc_r;
          out_empty_nxt = empty_r;
          out_full_nxt  = full_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_r      <= FREE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    key_r       <= key_nxt;
    node_r      <= node_nxt;
    lvl_r       <= lvl_nxt;
    acc_r       <= acc_nxt;
    fresh_r     <= fresh_nxt;
    empty_r     <= empty_nxt;
    full_r      <= full_nxt;
    out_best_r  <= out_best_nxt;
    out_empty_r <= out_empty_nxt;
    out_full_r  <= out_full_nxt;
  end

  // Node pool port: one write at the node being walked, one registered read
  // of the node for the next level.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pool_mem[node_r] <= wr_data;
    end
    rd_data_r <= pool_mem[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_best_xor   = out_best_r;
  assign out_trie_empty = out_empty_r;
  assign out_pool_full  = out_full_r;

  // The free pointer never runs past the end of the pool.
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, free_r} <= (FREE_W + 1)'(NODES))
    else $error("free node pointer beyond pool");

  // A clear leaves only the root in use.
  a_clear_free: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_func == FUNC_CLEAR) |=> (free_r == FREE_W'(1)))
    else $error("clear did not reset free pointer");

  // Once an operation is taken the block is busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("accepted a second item back to back");

  // A nonzero result only comes from a successful query.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_best_xor != '0) |-> !out_trie_empty && !out_pool_full)
    else $error("result has both data and an error flag");

endmodule
